>>> rtl/core/bpo_pkg.sv
// Shared types and constants for the bank partition optimizer.
// No dependencies; used by bpo_cell, bank_partition_optimizer and the testbench.
package bpo_pkg;

  localparam int unsigned MaxUnitsDef = 64;
  localparam int unsigned PosW        = 8;
  localparam int unsigned CntW        = 32;
  localparam int unsigned PfxW        = 38;
  localparam int unsigned CostW       = 16;
  localparam int unsigned TotW        = 64;
  localparam int unsigned CfgW        = 7;

  typedef logic [PosW-1:0] pos_t;

  typedef enum logic [1:0] {
    OP_LOAD_UNIT = 2'd0,
    OP_LOAD_COST = 2'd1,
    OP_RUN       = 2'd2,
    OP_NONE      = 2'd3
  } op_e;

  typedef enum logic [0:0] {
    REG_UNIT_COUNT = 1'b0,
    REG_MIN_BANK   = 1'b1
  } reg_e;

  typedef struct packed {
    logic load_en;
    logic shift_en;
  } cell_ctrl_t;

  function automatic logic [TotW-1:0] sat_add(input logic [TotW-1:0] a,
                                              input logic [TotW-1:0] b);
    logic [TotW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TotW] ? {TotW{1'b1}} : s[TotW-1:0];
  endfunction

endpackage

>>> rtl/core/bpo_cell.sv
// One cell of the unit count row: holds a unit's access count.
// Depends on bpo_pkg; instantiated by bank_partition_optimizer.
module bpo_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bpo_pkg::cell_ctrl_t         ctrl_i,
  input  logic [bpo_pkg::CntW-1:0]    load_val_i,
  input  logic [bpo_pkg::CntW-1:0]    shift_in_i,
  output logic [bpo_pkg::CntW-1:0]    cnt_o
);

  logic [bpo_pkg::CntW-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctrl_i.shift_en) begin
      cnt_q <= shift_in_i;
    end else if (ctrl_i.load_en) begin
      cnt_q <= load_val_i;
    end
  end

  assign cnt_o = cnt_q;

endmodule

>>> rtl/core/bank_partition_optimizer.sv
// Bank partition optimizer top level: count cell row, interval DP sequencer,
// table memories and output register. Depends on bpo_pkg and bpo_cell.
//
// Usage: input beats carry a kind in s_axis_tuser (0 load unit count, 1 load
// length cost, 2 run, 3 dropped) and index/value in s_axis_tdata. A run
// rotates the count cell row once to build prefix sums, then fills the
// interval table range by range: read, multiply and check, then a read and
// a compare per split candidate (about N^3/6 split candidates in all for
// m = 1), then a write. The split walk then reads and checks per descent step.
// Result beats leave through m_axis: cut points ascending with zero cost,
// then a beat with N, the best total cost and tlast set.
// s_axis_tready is low from a run beat until its final result sits in the
// output register. The output register holds a beat while m_axis_tready is
// low; the sequencer stalls behind it. Reset clears the control state, the
// counts and the configuration (N = 64, m = 8); the cost table and interval
// tables are not cleared and must be loaded before use. Configuration is written
// through cfg_we_i/cfg_idx_i/cfg_data_i by the user only while idle, not enforced by the block.
module bank_partition_optimizer #(
  parameter int unsigned MAX_UNITS = bpo_pkg::MaxUnitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [0:0]              cfg_idx_i,
  input  logic [6:0]              cfg_data_i,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [39:0]             s_axis_tdata,  // index[6:0], value[38:7], zero fill
  input  logic [1:0]              s_axis_tuser,  // opcode[1:0]
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [71:0]             m_axis_tdata,  // cut_point[6:0], total_cost[70:7], zero
  output logic                    m_axis_tlast
);

  localparam int unsigned AW    = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
  localparam int unsigned TW    = 2 * AW;
  localparam int unsigned DEPTH = 1 << TW;
  localparam int unsigned PW    = bpo_pkg::PosW;
  localparam int unsigned CW    = bpo_pkg::CntW;
  localparam int unsigned FW    = bpo_pkg::PfxW;
  localparam int unsigned LW    = bpo_pkg::CostW;
  localparam int unsigned TOT   = bpo_pkg::TotW;

  typedef enum logic [12:0] {
    ST_IDLE    = 13'b0000000000001,
    ST_PFX     = 13'b0000000000010,
    ST_RNG_RD  = 13'b0000000000100,
    ST_RNG_MUL = 13'b0000000001000,
    ST_RNG_CHK = 13'b0000000010000,
    ST_SPL_RD  = 13'b0000000100000,
    ST_SPL_CMP = 13'b0000001000000,
    ST_RNG_WR  = 13'b0000010000000,
    ST_TOT_RD  = 13'b0000100000000,
    ST_TOT_LD  = 13'b0001000000000,
    ST_WALK_RD = 13'b0010000000000,
    ST_WALK_CK = 13'b0100000000000,
    ST_EMIT    = 13'b1000000000000
  } state_e;

  state_e state_q;
  logic   fin_q;

  logic [6:0]   in_index;
  logic [CW-1:0] in_value;
  bpo_pkg::op_e in_op;
  logic         in_acc, idx_ok;

  assign in_op    = bpo_pkg::op_e'(s_axis_tuser);
  assign in_index = s_axis_tdata[6:0];
  assign in_value = s_axis_tdata[38:7];
  assign s_axis_tready = (state_q == ST_IDLE) && !fin_q;
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign idx_ok   = (in_index != 7'd0) && (PW'(in_index) <= PW'(MAX_UNITS));

  // configuration
  logic [6:0] unit_count_q, min_bank_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_count_q <= 7'd64;
      min_bank_q   <= 7'd8;
    end else if (cfg_we_i) begin
      case (bpo_pkg::reg_e'(cfg_idx_i))
        bpo_pkg::REG_UNIT_COUNT: unit_count_q <= cfg_data_i;
        bpo_pkg::REG_MIN_BANK:   min_bank_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // count cell row
  logic [CW-1:0] cnt [MAX_UNITS];
  logic          shift_en;
  logic [AW-1:0] load_pos;
  assign load_pos = AW'(in_index - 7'd1);

  for (genvar j = 0; j < MAX_UNITS; j++) begin : g_cell
    bpo_pkg::cell_ctrl_t ctrl;
    assign ctrl.shift_en = shift_en;
    assign ctrl.load_en  = in_acc && (in_op == bpo_pkg::OP_LOAD_UNIT) && idx_ok &&
                           (load_pos == AW'(j));
    bpo_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .load_val_i (in_value),
      .shift_in_i (cnt[(j + 1) % MAX_UNITS]),
      .cnt_o      (cnt[j])
    );
  end

  // sequencer registers
  bpo_pkg::pos_t n_q, m_q, len_q, i_q, l_q, a_q, b_q, p_q, e_q;
  logic [AW-1:0]  t_q;
  logic [FW-1:0]  acc_q;
  logic [TOT-1:0] best_q, total_q;
  logic [6:0]     bsplit_q;

  bpo_pkg::pos_t k;
  assign k = i_q + len_q - PW'(1);

  // memories
  logic [FW-1:0]  pf_mem [MAX_UNITS];
  logic [LW-1:0]  lc_mem [MAX_UNITS];
  logic [TOT-1:0] rc_mem [DEPTH];
  logic [6:0]     bs_mem [DEPTH];
  logic [FW-1:0]  pf_rd0_q, pf_rd1_q;
  logic [LW-1:0]  lc_rd_q;
  logic [TOT-1:0] rc_rd0_q, rc_rd1_q;
  logic [6:0]     bs_rd_q;

  logic [AW-1:0] pf_ra0, pf_ra1, lc_ra;
  logic [TW-1:0] rc_ra0, rc_ra1, tab_wa, bs_ra;
  logic          pf_we, tab_we;
  logic [FW-1:0] acc_d;

  function automatic logic [TW-1:0] taddr(input bpo_pkg::pos_t a, input bpo_pkg::pos_t b);
    logic [PW-1:0] am, bm;
    am = a - PW'(1);
    bm = b - PW'(1);
    return {am[AW-1:0], bm[AW-1:0]};
  endfunction

  assign acc_d  = acc_q + FW'(cnt[0]);
  assign pf_we  = (state_q == ST_PFX);
  assign pf_ra0 = AW'(k - PW'(1));
  assign pf_ra1 = AW'(i_q - PW'(2));
  assign lc_ra  = AW'(len_q - PW'(1));
  assign tab_we = (state_q == ST_RNG_WR);
  assign tab_wa = taddr(i_q, k);
  assign rc_ra0 = (state_q == ST_TOT_RD) ? taddr(PW'(1), n_q) : taddr(i_q, l_q);
  assign rc_ra1 = taddr(l_q + PW'(1), k);
  assign bs_ra  = taddr(a_q, b_q);
  assign shift_en = (state_q == ST_PFX);

  always_ff @(posedge clk_i) begin
    if (pf_we) begin
      pf_mem[t_q] <= acc_d;
    end
    pf_rd0_q <= pf_mem[pf_ra0];
    pf_rd1_q <= pf_mem[pf_ra1];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (in_op == bpo_pkg::OP_LOAD_COST) && idx_ok) begin
      lc_mem[load_pos] <= in_value[LW-1:0];
    end
    lc_rd_q <= lc_mem[lc_ra];
  end

  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      rc_mem[tab_wa] <= best_q;
    end
    rc_rd0_q <= rc_mem[rc_ra0];
    rc_rd1_q <= rc_mem[rc_ra1];
  end

  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      bs_mem[tab_wa] <= bsplit_q;
    end
    bs_rd_q <= bs_mem[bs_ra];
  end

  // range sum and product
  logic [FW-1:0]      rng_sum;
  logic [FW+LW-1:0]   prod;
  logic [TOT-1:0]     cand;
  bpo_pkg::pos_t      s_pos, n_cl, m_cl;
  assign rng_sum = pf_rd0_q - ((i_q == PW'(1)) ? '0 : pf_rd1_q);
  assign prod    = rng_sum * lc_rd_q;
  assign cand    = bpo_pkg::sat_add(rc_rd0_q, rc_rd1_q);
  assign s_pos   = PW'(bs_rd_q);
  assign n_cl    = (unit_count_q == 7'd0) ? PW'(1) :
                   (PW'(unit_count_q) > PW'(MAX_UNITS)) ? PW'(MAX_UNITS) : PW'(unit_count_q);
  assign m_cl    = (min_bank_q == 7'd0) ? PW'(1) : PW'(min_bank_q);

  // output register
  logic          out_valid_q, out_last_q, out_free;
  logic [6:0]    out_cut_q;
  logic [TOT-1:0] out_cost_q;
  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (m_axis_tready && !fin_q && (state_q != ST_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      if (fin_q && out_free) begin
        out_valid_q <= 1'b1;
        out_cut_q   <= n_q[6:0];
        out_cost_q  <= total_q;
        out_last_q  <= 1'b1;
        fin_q       <= 1'b0;
        state_q     <= ST_IDLE;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc && (in_op == bpo_pkg::OP_RUN)) begin
            n_q <= n_cl;
            m_q <= m_cl;
            if (m_cl > n_cl) begin
              total_q <= '0;
              fin_q   <= 1'b1;
            end else begin
              t_q     <= '0;
              acc_q   <= '0;
              state_q <= ST_PFX;
            end
          end
        end
        ST_PFX: begin
          acc_q <= acc_d;
          t_q   <= t_q + AW'(1);
          if (t_q == AW'(MAX_UNITS - 1)) begin
            len_q   <= m_q;
            i_q     <= PW'(1);
            state_q <= ST_RNG_RD;
          end
        end
        ST_RNG_RD:  state_q <= ST_RNG_MUL;
        ST_RNG_MUL: begin
          best_q   <= TOT'(prod);
          bsplit_q <= '0;
          l_q      <= i_q + m_q;
          state_q  <= ST_RNG_CHK;
        end
        ST_RNG_CHK: begin
          state_q <= ((k - i_q) >= (m_q << 1)) ? ST_SPL_RD : ST_RNG_WR;
        end
        ST_SPL_RD: state_q <= ST_SPL_CMP;
        ST_SPL_CMP: begin
          if (cand < best_q) begin
            best_q   <= cand;
            bsplit_q <= l_q[6:0];
          end
          l_q     <= l_q + PW'(1);
          state_q <= ((l_q + PW'(1) + m_q) <= k) ? ST_SPL_RD : ST_RNG_WR;
        end
        ST_RNG_WR: begin
          state_q <= ST_RNG_RD;
          if (k < n_q) begin
            i_q <= i_q + PW'(1);
          end else if (len_q < n_q) begin
            len_q <= len_q + PW'(1);
            i_q   <= PW'(1);
          end else begin
            state_q <= ST_TOT_RD;
          end
        end
        ST_TOT_RD: state_q <= ST_TOT_LD;
        ST_TOT_LD: begin
          total_q <= rc_rd0_q;
          p_q     <= PW'(1);
          a_q     <= PW'(1);
          b_q     <= n_q;
          state_q <= ST_WALK_RD;
        end
        ST_WALK_RD: state_q <= ST_WALK_CK;
        ST_WALK_CK: begin
          if ((bs_rd_q == 7'd0) || (s_pos <= a_q) || (s_pos >= b_q)) begin
            if (b_q >= n_q) begin
              fin_q   <= 1'b1;
              state_q <= ST_IDLE;
            end else begin
              e_q     <= b_q;
              state_q <= ST_EMIT;
            end
          end else begin
            if (p_q <= s_pos) begin
              b_q <= s_pos;
            end else begin
              a_q <= s_pos + PW'(1);
            end
            state_q <= ST_WALK_RD;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_cut_q   <= e_q[6:0];
            out_cost_q  <= '0;
            out_last_q  <= 1'b0;
            p_q         <= e_q + PW'(1);
            a_q         <= PW'(1);
            b_q         <= n_q;
            state_q     <= ST_WALK_RD;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_cost_q, out_cut_q};
  assign m_axis_tlast  = out_last_q;

endmodule

>>> rtl/core/bpo_checker.sv
// Port-level checks for bank_partition_optimizer, bound to the top level.
// Depends only on the top level's ports.
module bpo_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  a_cut_zero_cost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[70:7] == 64'd0)
    else $error("cut beat carries a cost");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input taken during a run");

endmodule

bind bank_partition_optimizer bpo_checker u_bpo_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

>>> tb/tb_bank_partition_optimizer.sv
// Self-checking testbench for bank_partition_optimizer: loads counts and costs,
// runs the interval partition and checks every cut point against a local predictor.
// Depends on bpo_pkg and the bank_partition_optimizer RTL.
module tb_bank_partition_optimizer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Units = 64;
  localparam int unsigned StallLimit = 400000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [0:0]  cfg_idx_i;
  logic [6:0]  cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tlast;

  bank_partition_optimizer #(.MAX_UNITS(Units)) uut (.*);

  typedef struct packed {
    logic [6:0]  cut;
    logic [63:0] cost;
    logic        last;
  } cut_beat_t;

  class partition_predictor;
    logic [31:0] unit_cnt[1:64];
    logic [15:0] len_cost[1:64];
    logic [63:0] rng_cost[1:64][1:64];
    logic [6:0]  split_at[1:64][1:64];
    logic [6:0]  n_reg, m_reg;
    cut_beat_t   cut_q[$];
    int          errors, beats_in, beats_out, runs;

    function new();
      for (int u = 1; u <= 64; u++) begin
        unit_cnt[u] = '0;
        len_cost[u] = '0;
      end
      n_reg = 7'd64;
      m_reg = 7'd8;
    endfunction

    function logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
    endfunction

    function int unsigned leaf_end(int unsigned p, int unsigned n);
      int unsigned a, b, s;
      a = 1;
      b = n;
      forever begin
        s = split_at[a][b];
        if (s == 0 || s <= a || s >= b) return b;
        if (p <= s) b = s;
        else a = s + 1;
      end
    endfunction

    function void partition(int unsigned n, int unsigned m);
      logic [37:0] pfx[0:64];
      logic [63:0] best, c;
      int unsigned k;
      pfx[0] = '0;
      for (int u = 1; u <= 64; u++) pfx[u] = pfx[u-1] + 38'(unit_cnt[u]);
      for (int unsigned len = m; len <= n; len++) begin
        for (int unsigned i = 1; i + len - 1 <= n; i++) begin
          k = i + len - 1;
          best = 64'(pfx[k] - pfx[i-1]) * 64'(len_cost[len]);
          split_at[i][k] = '0;
          if (k - i >= 2 * m) begin
            for (int unsigned l = i + m; l + m <= k; l++) begin
              c = add_sat(rng_cost[i][l], rng_cost[l+1][k]);
              if (c < best) begin
                best = c;
                split_at[i][k] = 7'(l);
              end
            end
          end
          rng_cost[i][k] = best;
        end
      end
    endfunction

    function void note_beat(bpo_pkg::op_e op, logic [6:0] idx, logic [31:0] val);
      int unsigned n, m, p, e, cnt;
      logic [63:0] total;
      beats_in++;
      case (op)
        bpo_pkg::OP_LOAD_UNIT: if (idx >= 1 && idx <= 64) unit_cnt[idx] = val;
        bpo_pkg::OP_LOAD_COST: if (idx >= 1 && idx <= 64) len_cost[idx] = val[15:0];
        bpo_pkg::OP_RUN: begin
          runs++;
          n = (n_reg == 0) ? 1 : (n_reg > 64) ? 64 : n_reg;
          m = (m_reg == 0) ? 1 : m_reg;
          total = '0;
          cnt = 0;
          if (m <= n) begin
            partition(n, m);
            total = rng_cost[1][n];
            p = 1;
            forever begin
              e = leaf_end(p, n);
              if (e >= n || cnt >= 63) break;
              cut_q.push_back('{cut: 7'(e), cost: '0, last: 1'b0});
              cnt++;
              p = e + 1;
            end
          end
          cut_q.push_back('{cut: 7'(n), cost: total, last: 1'b1});
        end
        default: ;
      endcase
    endfunction

    function void check_beat(cut_beat_t got);
      cut_beat_t exp;
      beats_out++;
      if (cut_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result cut=%0d cost=%0h last=%0b", $time,
                 got.cut, got.cost, got.last);
        return;
      end
      exp = cut_q.pop_front();
      if (got.cut !== exp.cut) begin
        errors++;
        $display("%0t: cut_point expected %0d actual %0d", $time, exp.cut, got.cut);
      end
      if (got.cost !== exp.cost) begin
        errors++;
        $display("%0t: total_cost expected %0h actual %0h", $time, exp.cost, got.cost);
      end
      if (got.last !== exp.last) begin
        errors++;
        $display("%0t: last expected %0b actual %0b", $time, exp.last, got.last);
      end
    endfunction
  endclass

  partition_predictor pred = new();
  bit quiet;
  bit hold_req;
  int stall_cycles;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // result side: check, then pick next ready
  always @(posedge clk_i) begin
    int hold;
    if (m_axis_tvalid && m_axis_tready)
      pred.check_beat('{cut: m_axis_tdata[6:0], cost: m_axis_tdata[70:7],
                        last: m_axis_tlast});
    if (hold_req && hold == 0) begin
      hold = 3000;
      hold_req = 1'b0;
    end
    if (hold > 0) begin
      hold--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= quiet || ($urandom_range(99) >= 28);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles > StallLimit) begin
      $display("%0t: no progress for %0d cycles", $time, StallLimit);
      $display("bank_partition_optimizer test failed");
      $finish;
    end
  end

  task automatic send(bpo_pkg::op_e op, logic [6:0] idx, logic [31:0] val);
    if (!quiet && $urandom_range(99) < 28) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {1'b0, val, idx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pred.note_beat(op, idx, val);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pred.cut_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_cfg(bpo_pkg::reg_e r, logic [6:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= r;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (r == bpo_pkg::REG_UNIT_COUNT) pred.n_reg = val;
    else pred.m_reg = val;
    @(posedge clk_i);
  endtask

  task automatic random_beat();
    int unsigned r;
    logic [31:0] v;
    r = $urandom_range(99);
    v = ($urandom_range(3) == 0) ? 32'($urandom_range(20)) : $urandom;
    if (r < 45) send(bpo_pkg::OP_LOAD_UNIT, 7'($urandom_range(1, 64)), v);
    else if (r < 58) send(bpo_pkg::OP_LOAD_COST, 7'($urandom_range(1, 64)), $urandom);
    else if (r < 78) send(bpo_pkg::OP_RUN, 7'($urandom), $urandom);
    else if (r < 92)
      send($urandom_range(1) ? bpo_pkg::OP_LOAD_UNIT : bpo_pkg::OP_LOAD_COST,
           ($urandom_range(3) == 0) ? 7'd0 : 7'($urandom_range(65, 127)), $urandom);
    else send(bpo_pkg::OP_NONE, 7'($urandom), $urandom);
  endtask

  initial begin
    logic [6:0] cfg_n[10] = '{7'd0, 7'd5, 7'd12, 7'd127, 7'd30, 7'd64, 7'd20, 7'd9,
                              7'd64, 7'd16};
    logic [6:0] cfg_m[10] = '{7'd0, 7'd1, 7'd2, 7'd60, 7'd40, 7'd64, 7'd3, 7'd127,
                              7'd1, 7'd4};
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= bpo_pkg::REG_UNIT_COUNT;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= bpo_pkg::OP_NONE;
    quiet = 1'b0;
    hold_req = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // fill the cost table so no run reads an unwritten entry
    for (int l = 1; l <= 64; l++)
      send(bpo_pkg::OP_LOAD_COST, 7'(l), (l == 64) ? 32'hFFFF_FFFF : $urandom);

    // directed: extremes, ignored beats, reload, run at reset config
    send(bpo_pkg::OP_LOAD_UNIT, 7'd1, 32'hFFFF_FFFF);
    send(bpo_pkg::OP_LOAD_UNIT, 7'd64, 32'hFFFF_FFFF);
    send(bpo_pkg::OP_LOAD_UNIT, 7'd32, 32'd0);
    send(bpo_pkg::OP_LOAD_UNIT, 7'd7, 32'd5);
    send(bpo_pkg::OP_LOAD_UNIT, 7'd7, 32'd123456);
    send(bpo_pkg::OP_LOAD_UNIT, 7'd0, 32'hDEAD_BEEF);
    send(bpo_pkg::OP_LOAD_UNIT, 7'd65, 32'h1234_5678);
    send(bpo_pkg::OP_LOAD_COST, 7'd127, 32'h5555_5555);
    send(bpo_pkg::OP_LOAD_COST, 7'd2, 32'hABCD_0000);
    send(bpo_pkg::OP_LOAD_COST, 7'd3, 32'h0000_FFFF);
    send(bpo_pkg::OP_NONE, 7'h7F, 32'hFFFF_FFFF);
    send(bpo_pkg::OP_RUN, 7'd0, 32'd0);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      if (ph < 10) begin
        write_cfg(bpo_pkg::REG_UNIT_COUNT, cfg_n[ph]);
        write_cfg(bpo_pkg::REG_MIN_BANK, cfg_m[ph]);
      end else begin
        write_cfg(bpo_pkg::REG_UNIT_COUNT, 7'($urandom_range(2, 24)));
        write_cfg(bpo_pkg::REG_MIN_BANK, 7'($urandom_range(1, 6)));
      end
      quiet = (ph == 8) || (ph == 11);
      if (ph == 2) hold_req = 1'b1;
      send(bpo_pkg::OP_RUN, 7'd1, 32'd0);
      if (ph == 8) begin
        drain();
        continue;
      end
      random_beat();
      send(bpo_pkg::OP_RUN, 7'($urandom), $urandom);
      if (ph == 2)
        repeat (2) send(bpo_pkg::OP_LOAD_UNIT, 7'($urandom_range(1, 64)), $urandom);
      drain();
    end

    $display("Covered %0d input beats, %0d runs, %0d result beats over 13 unit/bank settings,",
             pred.beats_in, pred.runs, pred.beats_out);
    $display("including dropped beats, clamped settings and a long result-side hold.");
    if (pred.errors == 0 && pred.cut_q.size() == 0) begin
      $display("bank_partition_optimizer test passed");
    end else begin
      $display("%0d mismatches, %0d results outstanding", pred.errors, pred.cut_q.size());
      $display("bank_partition_optimizer test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/bpo_pkg.sv
rtl/core/bpo_cell.sv
rtl/core/bank_partition_optimizer.sv
rtl/core/bpo_checker.sv
tb/tb_bank_partition_optimizer.sv
